>>> rtl/fte_pkg.sv
// fte_pkg: shared codes, entry constants and stream widths for the FAT12 table engine.
// No dependencies; used by fat12_table_engine_unit.
package fte_pkg;

   // action codes, carried in req_tuser
   localparam logic [2:0] ACT_FORMAT  = 3'd0;
   localparam logic [2:0] ACT_RD_ENT  = 3'd1;
   localparam logic [2:0] ACT_WR_ENT  = 3'd2;
   localparam logic [2:0] ACT_ALLOC   = 3'd3;
   localparam logic [2:0] ACT_ADVANCE = 3'd4;
   localparam logic [2:0] ACT_RD_BYTE = 3'd5;
   localparam logic [2:0] ACT_WR_BYTE = 3'd6;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_FREE  = 2'd1;
   localparam logic [1:0] ST_BAD_LINK = 2'd2;
   localparam logic [1:0] ST_RANGE    = 2'd3;

   // entry codes
   localparam logic [11:0] E_FREE    = 12'h000;
   localparam logic [11:0] E_RES_MIN = 12'hFF0;
   localparam logic [11:0] E_EOC_MIN = 12'hFF8;
   localparam logic [11:0] E_EOC_MAX = 12'hFFF;
   localparam logic [11:0] E_MEDIA   = 12'hFF0;
   localparam logic [11:0] E_FIRST   = 12'd2;

   // nibble masks
   localparam logic [7:0] LO_NIB = 8'h0F;
   localparam logic [7:0] HI_NIB = 8'hF0;

   // stream widths
   localparam int REQ_TDATA_W = 48;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_TUSER_W = 3;

   localparam int OFF_W = 13;   // byte offset of an entry: idx + idx/2, idx < 4096

   function automatic logic [OFF_W-1:0] entry_off(input logic [11:0] idx);
      entry_off = {1'b0, idx} + {2'b00, idx[11:1]};
   endfunction

endpackage

>>> rtl/fat12_table_engine_unit.sv
// fat12_table_engine_unit: FAT12 allocation table kept as packed 12-bit entries in one
// byte memory (one registered read port, one write port), driven by a small sequencer.
// Depends on fte_pkg.
//
// req: one word per action; req_tuser holds the action code, req_tdata cluster, value,
// byte_addr and byte_data. rsp: exactly one word per action; status and fresh in
// rsp_tuser, cluster_out, entry_value and byte_out in rsp_tdata. csr_wr_en/csr_wr_data
// set the media entry that format writes to entry 0; taken at any time.
// Steps: write byte writes the store in the accepting cycle; read byte reads it once;
// read entry reads its two bytes, write entry read-modify-writes them; allocate scans
// from cluster 2 and marks the first free entry end of chain; advance follows a link, or
// at end of chain allocates and links the old tail (two read-modify-writes); format
// writes each byte up to the end of the last entry.
// One action in flight at a time; req_tready rises again once the result has moved into
// the rsp register.
// Reset: the memory is swept to zero, one byte a cycle, with req not ready meanwhile.
// Stalls: a held rsp word does not block the next accept; the next result then waits in
// the engine until the rsp register frees up.
module fat12_table_engine_unit #(
   parameter int CLUSTER_LIMIT = 2730,
   parameter int BYTE_DEPTH    = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   // csr
   input  logic                               csr_wr_en,
   input  logic [11:0]                        csr_wr_data,  // media_entry
   // req
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [11:0] cluster, [23:12] value, [35:24] byte_addr, [43:36] byte_data, [47:44] zero
   input  logic [fte_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic [fte_pkg::REQ_TUSER_W-1:0]    req_tuser,    // [2:0] action
   // rsp
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [11:0] cluster_out, [23:12] entry_value, [31:24] byte_out
   output logic [fte_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic [fte_pkg::RSP_TUSER_W-1:0]    rsp_tuser     // [1:0] status, [2] fresh
);

   localparam int AW = $clog2(BYTE_DEPTH);
   localparam int OW = fte_pkg::OFF_W;

   // last entry whose two bytes fit in the store, within CLUSTER_LIMIT
   function automatic int last_fit_idx();
      int j;
      j = 0;
      for (int i = 0; i < CLUSTER_LIMIT; i++) begin
         if ((i + (i >> 1) + 1) < BYTE_DEPTH) j = i;
      end
      return j;
   endfunction

   localparam int LAST_FIT = last_fit_idx();
   localparam int FMT_END  = LAST_FIT + (LAST_FIT >> 1) + 1;   // last byte format touches
   localparam bit FMT_PART = ((LAST_FIT & 1) == 0);            // only its low nibble

   localparam logic [11:0]   EC_L      = 12'(CLUSTER_LIMIT);
   localparam logic [11:0]   EC_LAST   = 12'(CLUSTER_LIMIT - 1);
   localparam logic [OW:0]   BD_L      = (OW + 1)'(BYTE_DEPTH);
   localparam logic [AW-1:0] FMT_END_A = AW'(FMT_END);
   localparam logic [AW-1:0] CLR_LAST  = AW'(BYTE_DEPTH - 1);

   // sequencer states
   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_FMT    = 4'd2;
   localparam logic [3:0] S_ERD_LO = 4'd3;
   localparam logic [3:0] S_ERD_HI = 4'd4;
   localparam logic [3:0] S_ERD_EV = 4'd5;
   localparam logic [3:0] S_SC_LO  = 4'd6;
   localparam logic [3:0] S_SC_HI  = 4'd7;
   localparam logic [3:0] S_SC_EV  = 4'd8;
   localparam logic [3:0] S_P_RD   = 4'd9;
   localparam logic [3:0] S_P_W0   = 4'd10;
   localparam logic [3:0] S_P_W1   = 4'd11;
   localparam logic [3:0] S_BRD    = 4'd12;
   localparam logic [3:0] S_BEV    = 4'd13;
   localparam logic [3:0] S_RESP   = 4'd14;

   // byte store
   logic [7:0]    fat_mem [BYTE_DEPTH];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [7:0]    wr_data;
   logic          wr_en;

   // control
   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [11:0]   media_ff, media_in;
   logic          pend2_ff, pend2_in;     // link the old tail after marking the new one

   // working registers
   logic [2:0]    act_ff, act_in;
   logic [11:0]   cl_ff, cl_in;
   logic [11:0]   idx_ff, idx_in;
   logic [11:0]   put_idx_ff, put_idx_in;
   logic [11:0]   put_val_ff, put_val_in;
   logic [11:0]   baddr_ff, baddr_in;
   logic [7:0]    lo_ff, lo_in;
   logic [7:0]    old_ff, old_in;
   logic          fits_ff, fits_in;
   logic          par_ff, par_in;

   // pending result
   logic [1:0]    res_st_ff, res_st_in;
   logic [11:0]   res_cl_ff, res_cl_in;
   logic [11:0]   res_ev_ff, res_ev_in;
   logic [7:0]    res_byte_ff, res_byte_in;
   logic          res_fresh_ff, res_fresh_in;

   // rsp register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_st_ff, rsp_st_in;
   logic [11:0]   rsp_cl_ff, rsp_cl_in;
   logic [11:0]   rsp_ev_ff, rsp_ev_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_fresh_ff, rsp_fresh_in;

   // req fields
   logic [2:0]    r_action;
   logic [11:0]   r_cluster, r_value, r_baddr;
   logic [7:0]    r_bdata;
   logic          req_acc;
   logic          r_baddr_ok;

   // entry addressing
   logic [11:0]   ent_idx;
   logic [OW-1:0] ent_off, ent_off1;
   logic          ent_fits;
   logic [11:0]   ent_raw, ent_val;
   logic [OW-1:0] baddr_w;

   assign r_action  = req_tuser[2:0];
   assign r_cluster = req_tdata[11:0];
   assign r_value   = req_tdata[23:12];
   assign r_baddr   = req_tdata[35:24];
   assign r_bdata   = req_tdata[43:36];

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign r_baddr_ok = {{(OW + 1 - 12){1'b0}}, r_baddr} < BD_L;
   assign baddr_w    = {{(OW - 12){1'b0}}, baddr_ff};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_byte_ff, rsp_ev_ff, rsp_cl_ff};
   assign rsp_tuser  = {rsp_fresh_ff, rsp_st_ff};

   // which entry the memory ports are working on
   always_comb begin
      unique case (state_ff)
         S_SC_LO, S_SC_HI:       ent_idx = idx_ff;
         S_SC_EV:                ent_idx = idx_ff + 12'd1;   // prefetch next entry
         S_P_RD, S_P_W0, S_P_W1: ent_idx = put_idx_ff;
         default:                ent_idx = cl_ff;
      endcase
   end

   assign ent_off  = fte_pkg::entry_off(ent_idx);
   assign ent_off1 = ent_off + OW'(1);
   assign ent_fits = {1'b0, ent_off1} < BD_L;

   // entry assembled from its two bytes; entries past the store read as free
   assign ent_raw = par_ff ? {rd_data_ff, lo_ff[7:4]} : {rd_data_ff[3:0], lo_ff};
   assign ent_val = fits_ff ? ent_raw : fte_pkg::E_FREE;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      media_in     = csr_wr_en ? csr_wr_data : media_ff;
      pend2_in     = pend2_ff;
      act_in       = act_ff;
      cl_in        = cl_ff;
      idx_in       = idx_ff;
      put_idx_in   = put_idx_ff;
      put_val_in   = put_val_ff;
      baddr_in     = baddr_ff;
      lo_in        = lo_ff;
      old_in       = old_ff;
      fits_in      = fits_ff;
      par_in       = par_ff;
      res_st_in    = res_st_ff;
      res_cl_in    = res_cl_ff;
      res_ev_in    = res_ev_ff;
      res_byte_in  = res_byte_ff;
      res_fresh_in = res_fresh_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_st_in    = rsp_st_ff;
      rsp_cl_in    = rsp_cl_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_fresh_in = rsp_fresh_ff;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            if (cnt_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end

         S_IDLE: begin
            if (req_acc) begin
               act_in       = r_action;
               cl_in        = r_cluster;
               baddr_in     = r_baddr;
               pend2_in     = 1'b0;
               res_st_in    = fte_pkg::ST_OK;
               res_cl_in    = '0;
               res_ev_in    = '0;
               res_byte_in  = '0;
               res_fresh_in = 1'b0;
               state_in     = S_RESP;
               unique case (r_action)
                  fte_pkg::ACT_FORMAT: begin
                     cnt_in   = '0;
                     state_in = S_FMT;
                  end
                  fte_pkg::ACT_RD_ENT: begin
                     if (r_cluster >= EC_L) res_st_in = fte_pkg::ST_RANGE;
                     else state_in = S_ERD_LO;
                  end
                  fte_pkg::ACT_WR_ENT: begin
                     if (r_cluster >= EC_L) begin
                        res_st_in = fte_pkg::ST_RANGE;
                     end else begin
                        put_idx_in = r_cluster;
                        put_val_in = r_value;
                        state_in   = S_P_RD;
                     end
                  end
                  fte_pkg::ACT_ALLOC: begin
                     idx_in   = fte_pkg::E_FIRST;
                     state_in = S_SC_LO;
                  end
                  fte_pkg::ACT_ADVANCE: begin
                     if (r_cluster < fte_pkg::E_FIRST || r_cluster >= EC_L) begin
                        res_st_in = fte_pkg::ST_RANGE;
                     end else begin
                        state_in = S_ERD_LO;
                     end
                  end
                  fte_pkg::ACT_RD_BYTE: begin
                     if (r_baddr_ok) state_in = S_BRD;
                     else res_st_in = fte_pkg::ST_RANGE;
                  end
                  fte_pkg::ACT_WR_BYTE: begin
                     if (r_baddr_ok) begin
                        wr_en   = 1'b1;
                        wr_addr = AW'({{(OW - 12){1'b0}}, r_baddr});
                        wr_data = r_bdata;
                     end else begin
                        res_st_in = fte_pkg::ST_RANGE;
                     end
                  end
                  default: ;   // unused code: plain ok
               endcase
            end
         end

         // header bytes, zero fill, then the boundary byte (maybe shared with next entry)
         S_FMT: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            rd_addr = FMT_END_A;
            priority if (cnt_ff == AW'(0)) begin
               wr_data = media_ff[7:0];
            end else if (cnt_ff == AW'(1)) begin
               wr_data = {fte_pkg::E_EOC_MAX[3:0], media_ff[11:8]};
            end else if (cnt_ff == AW'(2)) begin
               wr_data = fte_pkg::E_EOC_MAX[11:4];
            end else if (cnt_ff == FMT_END_A) begin
               wr_data = FMT_PART ? (rd_data_ff & fte_pkg::HI_NIB) : 8'h00;
            end else begin
               wr_data = 8'h00;
            end
            if (cnt_ff == FMT_END_A) begin
               state_in = S_RESP;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end

         S_ERD_LO: begin
            rd_addr  = ent_off[AW-1:0];
            state_in = S_ERD_HI;
         end

         S_ERD_HI: begin
            rd_addr  = ent_off1[AW-1:0];
            lo_in    = rd_data_ff;
            fits_in  = ent_fits;
            par_in   = ent_idx[0];
            state_in = S_ERD_EV;
         end

         S_ERD_EV: begin
            res_ev_in = ent_val;
            state_in  = S_RESP;
            if (act_ff == fte_pkg::ACT_ADVANCE) begin
               priority if (ent_val >= fte_pkg::E_EOC_MIN) begin
                  idx_in   = fte_pkg::E_FIRST;
                  state_in = S_SC_LO;
               end else if (ent_val >= fte_pkg::E_FIRST && ent_val < fte_pkg::E_RES_MIN &&
                            ent_val < EC_L) begin
                  res_cl_in = ent_val;
               end else begin
                  res_st_in = fte_pkg::ST_BAD_LINK;
               end
            end
         end

         S_SC_LO: begin
            rd_addr  = ent_off[AW-1:0];
            state_in = S_SC_HI;
         end

         S_SC_HI: begin
            rd_addr  = ent_off1[AW-1:0];
            lo_in    = rd_data_ff;
            fits_in  = ent_fits;
            par_in   = ent_idx[0];
            state_in = S_SC_EV;
         end

         // test idx_ff, low byte of the next entry already on its way
         S_SC_EV: begin
            rd_addr = ent_off[AW-1:0];
            priority if (ent_val == fte_pkg::E_FREE) begin
               res_cl_in  = idx_ff;
               put_idx_in = idx_ff;
               put_val_in = fte_pkg::E_EOC_MIN;
               if (act_ff == fte_pkg::ACT_ADVANCE) begin
                  pend2_in     = 1'b1;
                  res_fresh_in = 1'b1;
               end
               state_in = S_P_RD;
            end else if (idx_ff == EC_LAST) begin
               res_st_in = fte_pkg::ST_NO_FREE;
               state_in  = S_RESP;
            end else begin
               idx_in   = idx_ff + 12'd1;
               state_in = S_SC_HI;
            end
         end

         // read-modify-write of one entry: fetch the byte it shares with a neighbour
         S_P_RD: begin
            rd_addr  = put_idx_ff[0] ? ent_off[AW-1:0] : ent_off1[AW-1:0];
            state_in = S_P_W0;
         end

         S_P_W0: begin
            old_in  = rd_data_ff;
            wr_en   = ent_fits;
            wr_addr = ent_off[AW-1:0];
            wr_data = put_idx_ff[0] ? {put_val_ff[3:0], rd_data_ff[3:0]} : put_val_ff[7:0];
            state_in = S_P_W1;
         end

         S_P_W1: begin
            wr_en   = ent_fits;
            wr_addr = ent_off1[AW-1:0];
            wr_data = put_idx_ff[0] ? put_val_ff[11:4] : {old_ff[7:4], put_val_ff[11:8]};
            if (pend2_ff) begin
               // old tail now points at the fresh cluster
               put_idx_in = cl_ff;
               put_val_in = res_cl_ff;
               pend2_in   = 1'b0;
               state_in   = S_P_RD;
            end else begin
               state_in = S_RESP;
            end
         end

         S_BRD: begin
            rd_addr  = baddr_w[AW-1:0];
            state_in = S_BEV;
         end

         S_BEV: begin
            res_byte_in = rd_data_ff;
            state_in    = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = res_st_ff;
               rsp_cl_in    = res_cl_ff;
               rsp_ev_in    = res_ev_ff;
               rsp_byte_in  = res_byte_ff;
               rsp_fresh_in = res_fresh_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // byte store, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         fat_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= fat_mem[rd_addr];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         media_ff     <= fte_pkg::E_MEDIA;
         pend2_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         media_ff     <= media_in;
         pend2_ff     <= pend2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      cl_ff        <= cl_in;
      idx_ff       <= idx_in;
      put_idx_ff   <= put_idx_in;
      put_val_ff   <= put_val_in;
      baddr_ff     <= baddr_in;
      lo_ff        <= lo_in;
      old_ff       <= old_in;
      fits_ff      <= fits_in;
      par_ff       <= par_in;
      res_st_ff    <= res_st_in;
      res_cl_ff    <= res_cl_in;
      res_ev_ff    <= res_ev_in;
      res_byte_ff  <= res_byte_in;
      res_fresh_ff <= res_fresh_in;
      rsp_st_ff    <= rsp_st_in;
      rsp_cl_ff    <= rsp_cl_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_fresh_ff <= rsp_fresh_in;
   end

endmodule
